// File: rtl/grce_pkg.sv
// Shared types and constants for the glyph row color expander.
// No dependencies; every other file in rtl/ uses it by scoped names.
`default_nettype none

package grce_pkg;

  localparam int GLYPH_HEIGHT = 16;
  localparam int SCAN_W = 13;
  localparam int PROD_W = SCAN_W + 16;
  localparam int COL_OFF_W = 13;

  localparam logic [1:0] MODE_32BPP = 2'd0;
  localparam logic [1:0] MODE_24BPP = 2'd1;
  localparam logic [1:0] MODE_16BPP = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] REG_PIXEL_MODE = 2'd0;
  localparam logic [1:0] REG_LINE_PITCH = 2'd1;
  localparam logic [1:0] REG_FRAME_BASE = 2'd2;

  localparam logic [15:0] PITCH_RESET = 16'd4096;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  bits;
    logic [31:0] color;
    logic [1:0]  mode;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

`default_nettype wire

// File: rtl/grce_front.sv
// Front end: takes glyph rows, forms the row base address, drops the unused mode.
// Depends on grce_pkg.
`default_nettype none

module grce_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [7:0]          cell_column,
  input  wire logic [7:0]          cell_row,
  input  wire logic [3:0]          glyph_line,
  input  wire logic [7:0]          glyph_bits,
  input  wire logic [31:0]         fg_color,
  input  wire logic [1:0]          pixel_mode,
  input  wire logic [15:0]         line_pitch,
  input  wire logic [31:0]         frame_base,
  input  wire logic                q_full,
  output grce_pkg::push_t          push
);

  logic                            s1_valid;
  logic [1:0]                      s1_mode;
  logic [grce_pkg::PROD_W-1:0]     s1_prod;
  logic [grce_pkg::COL_OFF_W-1:0]  s1_col_off;
  logic [7:0]                      s1_bits;
  logic [31:0]                     s1_color;

  logic                            advance;
  logic                            accept;
  logic [grce_pkg::SCAN_W-1:0]     scan;
  logic [grce_pkg::PROD_W-1:0]     prod;
  logic [grce_pkg::COL_OFF_W-1:0]  col_off;
  logic [grce_pkg::COL_OFF_W-1:0]  col_ext;

  assign advance = !s1_valid || (s1_mode == grce_pkg::MODE_NONE) || !q_full;
  assign busy    = !advance;
  assign accept  = start && advance;

  assign scan = grce_pkg::SCAN_W'(cell_row) * grce_pkg::SCAN_W'(grce_pkg::GLYPH_HEIGHT)
              + grce_pkg::SCAN_W'(glyph_line);
  assign prod = grce_pkg::PROD_W'(scan) * grce_pkg::PROD_W'(line_pitch);
  assign col_ext = grce_pkg::COL_OFF_W'(cell_column);

  always_comb begin
    unique case (pixel_mode)
      grce_pkg::MODE_32BPP: col_off = col_ext << 5;
      grce_pkg::MODE_24BPP: col_off = (col_ext << 4) + (col_ext << 3);
      default:              col_off = col_ext << 4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_mode    <= pixel_mode;
      s1_prod    <= prod;
      s1_col_off <= col_off;
      s1_bits    <= glyph_bits;
      s1_color   <= fg_color;
    end
  end

  always_comb begin
    push.valid       = s1_valid && (s1_mode != grce_pkg::MODE_NONE) && !q_full;
    push.entry.addr  = frame_base + 32'(s1_prod) + 32'(s1_col_off);
    push.entry.bits  = s1_bits;
    push.entry.color = s1_color;
    push.entry.mode  = s1_mode;
  end

endmodule

`default_nettype wire

// File: rtl/grce_queue.sv
// Two-entry queue of decoded rows between the front end and the writer.
// Depends on grce_pkg.
`default_nettype none

module grce_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire grce_pkg::push_t  push,
  output logic                  full,
  input  wire logic             pop,
  output grce_pkg::head_t       head
);

  grce_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_pop;

  assign full       = (count == 2'd2);
  assign do_pop     = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push.valid) - 2'(do_pop);
    end
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/grce_back.sv
// Writer: expands one queued row into framebuffer word writes, one per cycle.
// Depends on grce_pkg.
`default_nettype none

module grce_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire grce_pkg::head_t  head,
  output logic                  pop,
  output logic                  write_valid,
  output logic [31:0]           write_address,
  output logic [31:0]           write_data,
  output logic                  last_write
);

  logic             active;
  grce_pkg::entry_t cur;
  logic [2:0]       k;

  logic [2:0]       last_k;
  logic             fin;
  logic             take;
  logic [31:0]      word;
  logic [23:0]      c24;
  logic [15:0]      one;
  logic [3:0]       grp;
  logic [31:0]      p1, p2, p3, p4;
  logic [1:0]       j;
  logic [2:0]       sel;

  always_comb begin
    unique case (cur.mode)
      grce_pkg::MODE_24BPP: last_k = 3'd5;
      grce_pkg::MODE_16BPP: last_k = 3'd3;
      default:              last_k = 3'd7;
    endcase
  end

  assign fin  = active && (k == last_k);
  assign take = !active || fin;
  assign pop  = take && head.valid;

  assign c24 = cur.color[23:0];
  assign one = {cur.color[23:19], cur.color[15:10], cur.color[7:3]};
  assign grp = (k >= 3'd3) ? cur.bits[3:0] : cur.bits[7:4];
  assign j   = (k >= 3'd3) ? 2'(k - 3'd3) : k[1:0];
  assign p1  = grp[3] ? {8'h00, c24} : 32'h0;
  assign p2  = grp[2] ? {8'h00, c24} : 32'h0;
  assign p3  = grp[1] ? {8'h00, c24} : 32'h0;
  assign p4  = grp[0] ? {8'h00, c24} : 32'h0;
  assign sel = 3'd7 - k;

  always_comb begin
    unique case (cur.mode)
      grce_pkg::MODE_24BPP: begin
        unique case (j)
          2'd0:    word = p1 | (p2 << 24);
          2'd1:    word = (p2 >> 8) | (p3 << 16);
          default: word = (p3 >> 16) | (p4 << 8);
        endcase
      end
      grce_pkg::MODE_16BPP: begin
        word = {cur.bits[3'd6 - {k[1:0], 1'b0}] ? one : 16'h0,
                cur.bits[3'd7 - {k[1:0], 1'b0}] ? one : 16'h0};
      end
      default: word = cur.bits[sel] ? cur.color : 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      write_valid <= 1'b0;
    end else begin
      write_valid <= active;
      if (take) begin
        active <= head.valid;
      end
    end
    if (take) begin
      cur <= head.entry;
      k   <= 3'd0;
    end else begin
      k <= k + 3'd1;
    end
    write_address <= cur.addr + {27'd0, k, 2'b00};
    write_data    <= word;
    last_write    <= fin;
  end

endmodule

`default_nettype wire

// File: rtl/glyph_row_color_expander_core.sv
// Top level of the glyph row color expander: config registers, front end, queue, writer.
// Depends on grce_pkg, grce_front, grce_queue and grce_back.
//
// Use: drive one glyph row (cell_column, cell_row, glyph_line, glyph_bits,
// fg_color) with start; it is taken at a clock edge where start is high and
// busy is low. Each row gives framebuffer word writes on write_address,
// write_data and last_write, each shown for one cycle with write_valid high;
// last_write marks the final word of the row. The receiver cannot stall.
// Registers are written over cfg_valid/cfg_ready (always ready) with cfg_index
// and cfg_data: 0 pixel_mode, 1 line_pitch, 2 frame_base. Write them only
// while no row is in flight. Rows in pixel mode 3 produce no writes.
// A row passes the front-end stage register, a queue slot and the writer's row
// register, and its words leave through registered outputs. Throughput: the
// writer emits one word per cycle, and a row gives 8 words at 32 bpp, 6 at 24 bpp
// and 4 at 16 bpp; a two-row queue lets the front end keep taking rows while the
// writer works; a row already queued follows the last with no gap on the write port.
// Reset: clears the pipeline and queue and sets pixel_mode 0, line_pitch 4096,
// frame_base 0.
`default_nettype none

module glyph_row_color_expander_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  cell_column,
  input  wire logic [7:0]  cell_row,
  input  wire logic [3:0]  glyph_line,
  input  wire logic [7:0]  glyph_bits,
  input  wire logic [31:0] fg_color,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             write_valid,
  output logic [31:0]      write_address,
  output logic [31:0]      write_data,
  output logic             last_write
);

  logic [1:0]       pixel_mode;
  logic [15:0]      line_pitch;
  logic [31:0]      frame_base;

  grce_pkg::push_t  push;
  grce_pkg::head_t  head;
  logic             q_full;
  logic             pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= grce_pkg::MODE_32BPP;
      line_pitch <= grce_pkg::PITCH_RESET;
      frame_base <= 32'h0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        grce_pkg::REG_PIXEL_MODE: pixel_mode <= cfg_data[1:0];
        grce_pkg::REG_LINE_PITCH: line_pitch <= cfg_data[15:0];
        grce_pkg::REG_FRAME_BASE: frame_base <= cfg_data;
        default: ;
      endcase
    end
  end

  grce_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cell_column (cell_column),
    .cell_row    (cell_row),
    .glyph_line  (glyph_line),
    .glyph_bits  (glyph_bits),
    .fg_color    (fg_color),
    .pixel_mode  (pixel_mode),
    .line_pitch  (line_pitch),
    .frame_base  (frame_base),
    .q_full      (q_full),
    .push        (push)
  );

  grce_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  grce_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .write_valid   (write_valid),
    .write_address (write_address),
    .write_data    (write_data),
    .last_write    (last_write)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_glyph_row_color_expander_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for glyph_row_color_expander_core: directed table, then random rows.
// Predicts framebuffer word writes for 32, 24 and 16 bpp modes; depends on grce_pkg and the RTL.

module tb_glyph_row_color_expander_core;
  import grce_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ROWS = 110;
  localparam int CALM_AFTER = 85;
  localparam int NUM_DIRECTED = 20;

  typedef struct packed {
    logic [7:0]  cell_column;
    logic [7:0]  cell_row;
    logic [3:0]  glyph_line;
    logic [7:0]  glyph_bits;
    logic [31:0] fg_color;
  } glyph_row_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] data;
    logic        last;
  } fb_write_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] pitch;
    logic [31:0] base;
    glyph_row_t  glyph;
    logic        typed;
    logic [31:0] addr0;
    logic [31:0] data0;
  } dir_case_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [7:0]  cell_column;
  logic [7:0]  cell_row;
  logic [3:0]  glyph_line;
  logic [7:0]  glyph_bits;
  logic [31:0] fg_color;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        write_valid;
  logic [31:0] write_address;
  logic [31:0] write_data;
  logic        last_write;

  logic [1:0]  cfg_mode;
  logic [15:0] cfg_pitch;
  logic [31:0] cfg_base;

  fb_write_t   expected_writes[$];
  int          mismatch_count;
  int          quiet_cycles;
  bit          idling;

  dir_case_t directed_rows [NUM_DIRECTED] = '{
    '{MODE_32BPP, 16'd4096, 32'h0, '{8'd0, 8'd0, 4'd0, 8'h80, 32'hffffffff},
      1'b1, 32'h0, 32'hffffffff},
    '{MODE_32BPP, 16'd4096, 32'h0, '{8'd255, 8'd255, 4'd15, 8'hff, 32'ha5a5a5a5},
      1'b0, 32'h0, 32'h0},
    '{MODE_32BPP, 16'd4096, 32'h0, '{8'd0, 8'd0, 4'd0, 8'h00, 32'hffffffff},
      1'b1, 32'h0, 32'h0},
    '{MODE_32BPP, 16'd4096, 32'h0, '{8'd1, 8'd0, 4'd1, 8'h01, 32'h12345678},
      1'b0, 32'h0, 32'h0},
    '{MODE_24BPP, 16'd4096, 32'h0, '{8'd0, 8'd0, 4'd0, 8'h80, 32'hffffffff},
      1'b1, 32'h0, 32'h00ffffff},
    '{MODE_24BPP, 16'd4096, 32'h0, '{8'd0, 8'd0, 4'd0, 8'hff, 32'hffffffff},
      1'b0, 32'h0, 32'h0},
    '{MODE_24BPP, 16'd4096, 32'h0, '{8'd255, 8'd255, 4'd15, 8'h5a, 32'h00abcdef},
      1'b0, 32'h0, 32'h0},
    '{MODE_16BPP, 16'd4096, 32'h0, '{8'd0, 8'd0, 4'd0, 8'h80, 32'hffffffff},
      1'b1, 32'h0, 32'h0000ffff},
    '{MODE_16BPP, 16'd4096, 32'h0, '{8'd0, 8'd0, 4'd0, 8'h40, 32'hffffffff},
      1'b1, 32'h0, 32'hffff0000},
    '{MODE_16BPP, 16'd4096, 32'h0, '{8'd0, 8'd0, 4'd0, 8'hff, 32'h00f8fcf8},
      1'b0, 32'h0, 32'h0},
    '{MODE_16BPP, 16'd4096, 32'h0, '{8'd255, 8'd255, 4'd15, 8'haa, 32'h12345678},
      1'b0, 32'h0, 32'h0},
    '{MODE_NONE, 16'd4096, 32'h0, '{8'd0, 8'd0, 4'd0, 8'hff, 32'hffffffff},
      1'b0, 32'h0, 32'h0},
    '{MODE_NONE, 16'd4096, 32'h0, '{8'd255, 8'd255, 4'd15, 8'h3c, 32'h0},
      1'b0, 32'h0, 32'h0},
    '{MODE_32BPP, 16'd0, 32'hffffffff, '{8'd0, 8'd0, 4'd0, 8'h80, 32'h00000001},
      1'b1, 32'hffffffff, 32'h00000001},
    '{MODE_32BPP, 16'hffff, 32'hfffffff0, '{8'd255, 8'd255, 4'd15, 8'hff, 32'h80000000},
      1'b0, 32'h0, 32'h0},
    '{MODE_24BPP, 16'hffff, 32'hffffffff, '{8'd255, 8'd255, 4'd15, 8'hff, 32'hff000000},
      1'b0, 32'h0, 32'h0},
    '{MODE_16BPP, 16'hffff, 32'h80000000, '{8'd128, 8'd128, 4'd8, 8'h55, 32'hffffffff},
      1'b0, 32'h0, 32'h0},
    '{MODE_32BPP, 16'd1, 32'h0, '{8'd0, 8'd0, 4'd15, 8'h80, 32'hdeadbeef},
      1'b1, 32'h0000000f, 32'hdeadbeef},
    '{MODE_16BPP, 16'd0, 32'h0, '{8'd0, 8'd0, 4'd0, 8'h00, 32'hffffffff},
      1'b1, 32'h0, 32'h0},
    '{MODE_32BPP, 16'd4096, 32'h0, '{8'd0, 8'd1, 4'd0, 8'h80, 32'h0},
      1'b1, 32'h00010000, 32'h0}
  };

  glyph_row_color_expander_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cell_column   (cell_column),
    .cell_row      (cell_row),
    .glyph_line    (glyph_line),
    .glyph_bits    (glyph_bits),
    .fg_color      (fg_color),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .write_valid   (write_valid),
    .write_address (write_address),
    .write_data    (write_data),
    .last_write    (last_write)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  function automatic void push_write(input logic [31:0] addr, input logic [31:0] data,
                                     input logic last);
    fb_write_t wr;
    wr.addr = addr;
    wr.data = data;
    wr.last = last;
    expected_writes.push_back(wr);
  endfunction

  // Queue the word writes one glyph row produces under the current settings.
  function automatic int expand_glyph_row(input glyph_row_t g);
    logic [31:0] row_addr;
    logic [31:0] addr;
    logic [31:0] rgb24;
    logic [15:0] rgb565;
    logic [31:0] px [8];
    logic [31:0] p1, p2, p3, p4;
    int          k;
    int          grp;
    int          n;
    row_addr = cfg_base + (32'(g.cell_row) * GLYPH_HEIGHT + 32'(g.glyph_line)) *
               32'(cfg_pitch);
    n = 0;
    case (cfg_mode)
      MODE_32BPP: begin
        addr = row_addr + 32'(g.cell_column) * 32'd32;
        for (k = 0; k < 8; k++) begin
          push_write(addr + 32'(4 * k), g.glyph_bits[7 - k] ? g.fg_color : 32'h0, k == 7);
        end
        n = 8;
      end
      MODE_24BPP: begin
        rgb24 = {8'h00, g.fg_color[23:0]};
        for (k = 0; k < 8; k++) px[k] = g.glyph_bits[7 - k] ? rgb24 : 32'h0;
        addr = row_addr + 32'(g.cell_column) * 32'd24;
        for (grp = 0; grp < 2; grp++) begin
          p1 = px[4 * grp];
          p2 = px[4 * grp + 1];
          p3 = px[4 * grp + 2];
          p4 = px[4 * grp + 3];
          push_write(addr + 32'(12 * grp), p1 | (p2 << 24), 1'b0);
          push_write(addr + 32'(12 * grp + 4), (p2 >> 8) | (p3 << 16), 1'b0);
          push_write(addr + 32'(12 * grp + 8), (p3 >> 16) | (p4 << 8), grp == 1);
        end
        n = 6;
      end
      MODE_16BPP: begin
        rgb565 = {g.fg_color[23:19], g.fg_color[15:10], g.fg_color[7:3]};
        addr = row_addr + 32'(g.cell_column) * 32'd16;
        for (k = 0; k < 4; k++) begin
          push_write(addr + 32'(4 * k),
                     {g.glyph_bits[6 - 2 * k] ? rgb565 : 16'h0,
                      g.glyph_bits[7 - 2 * k] ? rgb565 : 16'h0}, k == 3);
        end
        n = 4;
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  task automatic drive_glyph_row(input glyph_row_t g, input logic typed,
                                 input logic [31:0] addr0, input logic [31:0] data0);
    int        burst;
    int        n;
    fb_write_t wr;
    if (idling && $urandom_range(0, 3) == 0) begin
      burst = $urandom_range(1, 5);
      @(negedge clk);
      start = 1'b0;
      repeat (burst - 1) @(negedge clk);
    end
    @(negedge clk);
    start       = 1'b1;
    cell_column = g.cell_column;
    cell_row    = g.cell_row;
    glyph_line  = g.glyph_line;
    glyph_bits  = g.glyph_bits;
    fg_color    = g.fg_color;
    do @(posedge clk); while (busy !== 1'b0);
    n = expand_glyph_row(g);
    if (typed && n > 0) begin
      wr = expected_writes[expected_writes.size() - n];
      wr.addr = addr0;
      wr.data = data0;
      expected_writes[expected_writes.size() - n] = wr;
    end
  endtask

  task automatic wait_for_writes();
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_PIXEL_MODE: cfg_mode = value[1:0];
      REG_LINE_PITCH: cfg_pitch = value[15:0];
      REG_FRAME_BASE: cfg_base = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(input logic [1:0] mode, input logic [15:0] pitch,
                                input logic [31:0] base, input bit write_all);
    if (write_all || mode != cfg_mode || pitch != cfg_pitch || base != cfg_base) begin
      @(negedge clk);
      start = 1'b0;
      wait_for_writes();
      if (write_all || mode != cfg_mode) write_register(REG_PIXEL_MODE, 32'(mode));
      if (write_all || pitch != cfg_pitch) write_register(REG_LINE_PITCH, 32'(pitch));
      if (write_all || base != cfg_base) write_register(REG_FRAME_BASE, base);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  always @(posedge clk) begin
    fb_write_t wr;
    if (!rst && write_valid === 1'b1) begin
      if (expected_writes.size() == 0) begin
        note_mismatch($sformatf("unexpected write addr %h data %h", write_address, write_data));
      end else begin
        wr = expected_writes.pop_front();
        if (write_address !== wr.addr)
          note_mismatch($sformatf("write_address got %h, expected %h", write_address, wr.addr));
        if (write_data !== wr.data)
          note_mismatch($sformatf("write_data got %h, expected %h at %h",
                                  write_data, wr.data, wr.addr));
        if (last_write !== wr.last)
          note_mismatch($sformatf("last_write got %b, expected %b at %h",
                                  last_write, wr.last, wr.addr));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || write_valid === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    glyph_row_t  g;
    logic [1:0]  mode;
    logic [15:0] pitch;
    logic [31:0] base;
    int          counted;
    int          batch;
    int          i;
    rst            = 1'b1;
    start          = 1'b0;
    cell_column    = '0;
    cell_row       = '0;
    glyph_line     = '0;
    glyph_bits     = '0;
    fg_color       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    cfg_mode       = MODE_32BPP;
    cfg_pitch      = PITCH_RESET;
    cfg_base       = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    idling         = 1'b1;
    counted        = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      apply_settings(directed_rows[i].mode, directed_rows[i].pitch,
                     directed_rows[i].base, 1'b0);
      drive_glyph_row(directed_rows[i].glyph, directed_rows[i].typed,
                      directed_rows[i].addr0, directed_rows[i].data0);
    end

    while (counted < RANDOM_ROWS) begin
      mode = ($urandom_range(0, 7) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0: pitch = 16'h0000;
        1: pitch = 16'hffff;
        default: pitch = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 3))
        0: base = 32'h0;
        1: base = 32'hffffffff;
        default: base = $urandom;
      endcase
      apply_settings(mode, pitch, base, 1'b1);
      idling = (counted < CALM_AFTER);
      batch = (mode == MODE_NONE) ? $urandom_range(2, 5) : $urandom_range(8, 20);
      for (i = 0; i < batch && counted < RANDOM_ROWS; i++) begin
        g.cell_column = pick_byte();
        g.cell_row    = pick_byte();
        g.glyph_line  = 4'($urandom_range(0, 15));
        g.glyph_bits  = pick_byte();
        g.fg_color    = ($urandom_range(0, 7) == 0) ? 32'hffffffff : $urandom;
        drive_glyph_row(g, 1'b0, 32'h0, 32'h0);
        counted++;
      end
    end

    @(negedge clk);
    start = 1'b0;
    wait_for_writes();
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
